// File: hw/rtl/tstmc_pkg.sv
// Shared types and constants for the touch sample trimmed-mean calibrator.
// Used by every module of the block; depends on nothing.
package tstmc_pkg;

	// Field widths.
	localparam int RAW_W       = 13;
	localparam int PIX_W       = 10;
	localparam int GAIN_W      = 16;
	localparam int SUM_W       = 17;
	localparam int COUNT_W     = 4;
	localparam int MEAN_W      = 13;
	localparam int PROD_W      = GAIN_W + MEAN_W;
	localparam int BASE_W      = PIX_W + 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Kept samples per point; the trimmed mean divides the middle eight by a shift of 3.
	localparam int SAMPLE_COUNT = 10;
	localparam int MEAN_SHIFT   = 3;

	// Default depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_X_OFFSET      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_X_GAIN        = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_Y_OFFSET      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_Y_GAIN        = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SWAP_AXES     = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_HEIGHT = 3'd7;

	// Input sample transaction.
	typedef struct packed {
		logic             pen_down;
		logic [RAW_W-1:0] x_raw;
		logic [RAW_W-1:0] y_raw;
	} sample_t;

	// Output point transaction.
	typedef struct packed {
		logic             point_valid;
		logic [PIX_W-1:0] point_x;
		logic [PIX_W-1:0] point_y;
	} point_t;

	// Acceptance window used by the front part.
	typedef struct packed {
		logic [RAW_W-1:0] low_limit;
		logic [RAW_W-1:0] high_limit;
	} window_t;

	// Calibration settings used by the back part.
	typedef struct packed {
		logic [PIX_W-1:0]  x_offset;
		logic [GAIN_W-1:0] x_gain;
		logic [PIX_W-1:0]  y_offset;
		logic [GAIN_W-1:0] y_gain;
		logic              swap_axes;
		logic [PIX_W-1:0]  mirror_height;
	} calib_t;

	// One queued job: a finished accumulation or a pen-up event.
	typedef struct packed {
		logic             pen_down;
		logic [SUM_W-1:0] x_sum;
		logic [RAW_W-1:0] x_min;
		logic [RAW_W-1:0] x_max;
		logic [SUM_W-1:0] y_sum;
		logic [RAW_W-1:0] y_min;
		logic [RAW_W-1:0] y_max;
	} job_t;

	// Queue status seen by the front part.
	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

endpackage

// File: hw/rtl/tstmc_front.sv
// Front part: accepts samples, applies the window, keeps sums and extremes.
// Pushes a job into the queue on the last kept sample or on pen-up. Uses tstmc_pkg.
module tstmc_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tstmc_pkg::sample_t       smp,
	input  logic                     smp_valid,
	output logic                     smp_stall,
	input  tstmc_pkg::window_t       window,
	input  tstmc_pkg::queue_status_t q_status,
	output logic                     push,
	output tstmc_pkg::job_t          job
);

	logic [tstmc_pkg::COUNT_W-1:0] count_q;
	logic [tstmc_pkg::SUM_W-1:0]   x_sum_q, y_sum_q;
	logic [tstmc_pkg::RAW_W-1:0]   x_min_q, x_max_q, y_min_q, y_max_q;

	logic                          accept, in_window, kept, first, done;
	logic [tstmc_pkg::SUM_W-1:0]   x_sum_n, y_sum_n;
	logic [tstmc_pkg::RAW_W-1:0]   x_min_n, x_max_n, y_min_n, y_max_n;

	// Stall only while the queue has no room for a job.
	assign smp_stall = q_status.full;
	assign accept    = smp_valid && !q_status.full;

	// Window test: both axes strictly inside the limits.
	assign in_window = (smp.x_raw > window.low_limit) && (smp.x_raw < window.high_limit) &&
	                   (smp.y_raw > window.low_limit) && (smp.y_raw < window.high_limit);
	assign kept   = accept && smp.pen_down && in_window;
	assign first  = (count_q == '0);
	assign done   = kept && (count_q == tstmc_pkg::COUNT_W'(tstmc_pkg::SAMPLE_COUNT - 1));

	// Running sums and extremes including the current sample.
	always_comb begin
		x_sum_n = x_sum_q + tstmc_pkg::SUM_W'(smp.x_raw);
		y_sum_n = y_sum_q + tstmc_pkg::SUM_W'(smp.y_raw);
		x_min_n = (first || smp.x_raw < x_min_q) ? smp.x_raw : x_min_q;
		x_max_n = (first || smp.x_raw > x_max_q) ? smp.x_raw : x_max_q;
		y_min_n = (first || smp.y_raw < y_min_q) ? smp.y_raw : y_min_q;
		y_max_n = (first || smp.y_raw > y_max_q) ? smp.y_raw : y_max_q;
	end

	// A job leaves on pen-up or when the last sample of a set is kept.
	assign push         = accept && (!smp.pen_down || done);
	assign job.pen_down = smp.pen_down;
	assign job.x_sum    = x_sum_n;
	assign job.x_min    = x_min_n;
	assign job.x_max    = x_max_n;
	assign job.y_sum    = y_sum_n;
	assign job.y_min    = y_min_n;
	assign job.y_max    = y_max_n;

	// Accumulator state: cleared by every emitted job, updated by kept samples.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			x_sum_q <= '0;
			y_sum_q <= '0;
			x_min_q <= '0;
			x_max_q <= '0;
			y_min_q <= '0;
			y_max_q <= '0;
		end else if (push) begin
			count_q <= '0;
			x_sum_q <= '0;
			y_sum_q <= '0;
			x_min_q <= '0;
			x_max_q <= '0;
			y_min_q <= '0;
			y_max_q <= '0;
		end else if (kept) begin
			count_q <= count_q + 1'b1;
			x_sum_q <= x_sum_n;
			y_sum_q <= y_sum_n;
			x_min_q <= x_min_n;
			x_max_q <= x_max_n;
			y_min_q <= y_min_n;
			y_max_q <= y_max_n;
		end
	end

endmodule

// File: hw/rtl/tstmc_fifo.sv
// Short job queue between the front and back parts.
// Holds tstmc_pkg::job_t entries; depth set by the DEPTH parameter.
module tstmc_fifo #(
	parameter int DEPTH = tstmc_pkg::QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  tstmc_pkg::job_t          push_job,
	input  logic                     pop,
	output tstmc_pkg::job_t          pop_job,
	output tstmc_pkg::queue_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tstmc_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign status.full      = (count_q == CNT_W'(DEPTH));
	assign status.not_empty = (count_q != '0);
	assign do_push          = push && !status.full;
	assign do_pop           = pop && status.not_empty;
	assign pop_job          = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/tstmc_back.sv
// Back part: trimmed mean, gain and offset, axis swap, output register.
// Three elastic stages fed from the job queue. Uses tstmc_pkg.
module tstmc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tstmc_pkg::calib_t  calib,
	input  logic               job_ready,
	input  tstmc_pkg::job_t    job,
	output logic               pop,
	output tstmc_pkg::point_t  pt,
	output logic               pt_valid,
	input  logic               pt_stall
);

	logic                           valid_s1, valid_s2;
	logic                           pen_s1, pen_s2;
	logic [tstmc_pkg::MEAN_W-1:0]   x_mean_s1, y_mean_s1;
	logic [tstmc_pkg::PROD_W-1:0]   x_prod_s2, y_prod_s2;
	logic                           free_s3, free_s2, free_s1;
	logic [tstmc_pkg::SUM_W-1:0]    x_mid, y_mid;
	logic [tstmc_pkg::PIX_W-1:0]    x_cal, y_cal, mirror_y;
	tstmc_pkg::point_t              pt_n;

	// Handshake between stages: a stage may load when it is empty or moving on.
	assign free_s3 = !pt_valid || !pt_stall;
	assign free_s2 = !valid_s2 || free_s3;
	assign free_s1 = !valid_s1 || free_s2;
	assign pop     = job_ready && free_s1;

	// Stage 1: drop the extremes and shift the middle sum down to the mean.
	assign x_mid = job.x_sum - tstmc_pkg::SUM_W'(job.x_min) - tstmc_pkg::SUM_W'(job.x_max);
	assign y_mid = job.y_sum - tstmc_pkg::SUM_W'(job.y_min) - tstmc_pkg::SUM_W'(job.y_max);

	always_ff @(posedge clk) begin
		if (pop) begin
			pen_s1    <= job.pen_down;
			x_mean_s1 <= x_mid[tstmc_pkg::MEAN_SHIFT +: tstmc_pkg::MEAN_W];
			y_mean_s1 <= y_mid[tstmc_pkg::MEAN_SHIFT +: tstmc_pkg::MEAN_W];
		end
	end

	// Stage 2: gain times mean, one multiplier per axis.
	always_ff @(posedge clk) begin
		if (valid_s1 && free_s2) begin
			pen_s2    <= pen_s1;
			x_prod_s2 <= tstmc_pkg::PROD_W'(calib.x_gain) * tstmc_pkg::PROD_W'(x_mean_s1);
			y_prod_s2 <= tstmc_pkg::PROD_W'(calib.y_gain) * tstmc_pkg::PROD_W'(y_mean_s1);
		end
	end

	// Offset minus product, floored and saturated at zero.
	function automatic logic [tstmc_pkg::PIX_W-1:0] offset_sub(
		input logic [tstmc_pkg::PIX_W-1:0]  offset,
		input logic [tstmc_pkg::PROD_W-1:0] prod
	);
		logic [tstmc_pkg::PROD_W-1:0] base;
		logic [tstmc_pkg::PROD_W-1:0] diff;
		base = tstmc_pkg::PROD_W'({offset, 16'h0000});
		diff = base - prod;
		if (prod >= base) begin
			return '0;
		end
		return diff[16 +: tstmc_pkg::PIX_W];
	endfunction

	// Stage 3: calibration, optional swap with mirrored Y, zero point on pen-up.
	always_comb begin
		x_cal    = offset_sub(calib.x_offset, x_prod_s2);
		y_cal    = offset_sub(calib.y_offset, y_prod_s2);
		mirror_y = (calib.mirror_height > x_cal) ? (calib.mirror_height - x_cal) : '0;
		pt_n.point_valid = pen_s2;
		if (!pen_s2) begin
			pt_n.point_x = '0;
			pt_n.point_y = '0;
		end else if (calib.swap_axes) begin
			pt_n.point_x = y_cal;
			pt_n.point_y = mirror_y;
		end else begin
			pt_n.point_x = x_cal;
			pt_n.point_y = y_cal;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && free_s3) begin
			pt <= pt_n;
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pt_valid <= 1'b0;
		end else begin
			if (free_s1) begin
				valid_s1 <= pop;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (free_s3) begin
				pt_valid <= valid_s2;
			end
		end
	end

endmodule

// File: hw/rtl/touch_sample_trimmed_mean_calibrate.sv
// Resistive touch trimmed-mean filter with calibration. The block takes one sample
// transaction per clock cycle: the front part tests the window and updates sums,
// minima and maxima in the cycle that accepts the sample. The tenth kept sample or
// a pen-up sample places a job in a FIFO_DEPTH-entry queue; the back part turns each
// job into a point in three stages (trimmed mean, gain multiply, offset and swap into
// the output register), and finishes one job per cycle while jobs wait and pt_stall
// is low. Samples stall only while the queue is full. Configuration writes take
// effect at the next edge and should be made while no point is pending.
module touch_sample_trimmed_mean_calibrate #(
	parameter int FIFO_DEPTH = tstmc_pkg::QUEUE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tstmc_pkg::sample_t                   smp,
	input  logic                                 smp_valid,
	output logic                                 smp_stall,
	output tstmc_pkg::point_t                    pt,
	output logic                                 pt_valid,
	input  logic                                 pt_stall,
	input  logic                                 cfg_we,
	input  logic [tstmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tstmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	tstmc_pkg::window_t       window_q;
	tstmc_pkg::calib_t        calib_q;
	tstmc_pkg::queue_status_t q_status;
	tstmc_pkg::job_t          push_job, pop_job;
	logic                     q_push, q_pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q.low_limit     <= 13'd100;
			window_q.high_limit    <= 13'd4000;
			calib_q.x_offset       <= 10'd253;
			calib_q.x_gain         <= 16'd4375;
			calib_q.y_offset       <= 10'd348;
			calib_q.y_gain         <= 16'd5916;
			calib_q.swap_axes      <= 1'b0;
			calib_q.mirror_height  <= 10'd240;
		end else if (cfg_we) begin
			case (cfg_index)
				tstmc_pkg::REG_LOW_LIMIT:     window_q.low_limit    <= cfg_data[12:0];
				tstmc_pkg::REG_HIGH_LIMIT:    window_q.high_limit   <= cfg_data[12:0];
				tstmc_pkg::REG_X_OFFSET:      calib_q.x_offset      <= cfg_data[9:0];
				tstmc_pkg::REG_X_GAIN:        calib_q.x_gain        <= cfg_data;
				tstmc_pkg::REG_Y_OFFSET:      calib_q.y_offset      <= cfg_data[9:0];
				tstmc_pkg::REG_Y_GAIN:        calib_q.y_gain        <= cfg_data;
				tstmc_pkg::REG_SWAP_AXES:     calib_q.swap_axes     <= cfg_data[0];
				tstmc_pkg::REG_MIRROR_HEIGHT: calib_q.mirror_height <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// Front part: window test and accumulation.
	tstmc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp       (smp),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.window    (window_q),
		.q_status  (q_status),
		.push      (q_push),
		.job       (push_job)
	);

	// Job queue.
	tstmc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.status   (q_status)
	);

	// Back part: mean, calibration and output register.
	tstmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.calib     (calib_q),
		.job_ready (q_status.not_empty),
		.job       (pop_job),
		.pop       (q_pop),
		.pt        (pt),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall)
	);

	// The front part never pushes a job into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_status.full)
		else $error("job pushed into a full queue");

	// A pen-up transaction carries a zero point.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pt_valid && !pt.point_valid) |-> (pt.point_x == '0 && pt.point_y == '0))
		else $error("pen-up point with nonzero coordinates");

	// Without swapping, the calibrated X never exceeds its offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pt_valid && pt.point_valid && !calib_q.swap_axes) |-> (pt.point_x <= calib_q.x_offset))
		else $error("calibrated X above offset");

	// The queue never pops while empty.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_status.not_empty)
		else $error("job popped from an empty queue");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the touch sample trimmed-mean calibrator.
// It drives sample transactions and register writes, predicts every point in a
// scoreboard class, and depends only on tstmc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
	import tstmc_pkg::*;

	localparam int GAIN_FRAC     = 16;
	localparam int SETTLE_CYCLES = 16;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASES        = 8;

	// Predicts points from accepted samples and checks the points that come out.
	class point_scoreboard;
		logic [RAW_W-1:0]   low_limit, high_limit;
		logic [PIX_W-1:0]   x_offset, y_offset, mirror_height;
		logic [GAIN_W-1:0]  x_gain, y_gain;
		logic               swap_axes;
		logic [COUNT_W-1:0] kept_count;
		logic [SUM_W-1:0]   x_sum, y_sum;
		logic [RAW_W-1:0]   x_min, x_max, y_min, y_max;
		point_t             expected_points[$];
		int unsigned        mismatch_count, samples_seen, kept_seen, valid_seen, pen_up_seen;

		function new();
			low_limit     = 13'd100;
			high_limit    = 13'd4000;
			x_offset      = 10'd253;
			x_gain        = 16'd4375;
			y_offset      = 10'd348;
			y_gain        = 16'd5916;
			swap_axes     = 1'b0;
			mirror_height = 10'd240;
			clear_touch();
		endfunction

		function void clear_touch();
			kept_count = '0;
			x_sum      = '0;
			y_sum      = '0;
			x_min      = '0;
			x_max      = '0;
			y_min      = '0;
			y_max      = '0;
		endfunction

		function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_LOW_LIMIT:     low_limit = data[RAW_W-1:0];
				REG_HIGH_LIMIT:    high_limit = data[RAW_W-1:0];
				REG_X_OFFSET:      x_offset = data[PIX_W-1:0];
				REG_X_GAIN:        x_gain = data[GAIN_W-1:0];
				REG_Y_OFFSET:      y_offset = data[PIX_W-1:0];
				REG_Y_GAIN:        y_gain = data[GAIN_W-1:0];
				REG_SWAP_AXES:     swap_axes = data[0];
				REG_MIRROR_HEIGHT: mirror_height = data[PIX_W-1:0];
				default: ;
			endcase
		endfunction

		// Offset minus Q0.16 gain times mean, floored, clamped at zero.
		function logic [PIX_W-1:0] calibrated(input logic [PIX_W-1:0] offset,
				input logic [GAIN_W-1:0] gain, input logic [MEAN_W:0] mean);
			logic [PROD_W:0] scaled_offset, product;
			scaled_offset = (PROD_W+1)'({offset, {GAIN_FRAC{1'b0}}});
			product = (PROD_W+1)'(gain) * (PROD_W+1)'(mean);
			if (product >= scaled_offset)
				return '0;
			scaled_offset = scaled_offset - product;
			return scaled_offset[BASE_W-1:GAIN_FRAC];
		endfunction

		// Accumulates one accepted sample and queues the point it completes, if any.
		function void note_sample(input sample_t s);
			logic [SUM_W-1:0]  x_trim, y_trim;
			logic [MEAN_W:0]   x_mean, y_mean;
			logic [PIX_W-1:0]  cal_x, cal_y, old_x;
			point_t            p;
			samples_seen++;
			if (!s.pen_down) begin
				clear_touch();
				p = '0;
				expected_points.push_back(p);
				pen_up_seen++;
				return;
			end
			if (!(s.x_raw > low_limit && s.x_raw < high_limit &&
					s.y_raw > low_limit && s.y_raw < high_limit))
				return;
			kept_seen++;
			if (kept_count == 0) begin
				x_min = s.x_raw;
				x_max = s.x_raw;
				y_min = s.y_raw;
				y_max = s.y_raw;
			end else begin
				if (s.x_raw < x_min) x_min = s.x_raw;
				if (s.x_raw > x_max) x_max = s.x_raw;
				if (s.y_raw < y_min) y_min = s.y_raw;
				if (s.y_raw > y_max) y_max = s.y_raw;
			end
			x_sum = x_sum + s.x_raw;
			y_sum = y_sum + s.y_raw;
			kept_count = kept_count + 1'b1;
			if (kept_count < SAMPLE_COUNT)
				return;

			// Drop the extremes of each axis and average the middle eight.
			x_trim = x_sum - x_min - x_max;
			y_trim = y_sum - y_min - y_max;
			x_mean = (MEAN_W+1)'(x_trim >> MEAN_SHIFT);
			y_mean = (MEAN_W+1)'(y_trim >> MEAN_SHIFT);
			cal_x = calibrated(x_offset, x_gain, x_mean);
			cal_y = calibrated(y_offset, y_gain, y_mean);
			if (swap_axes) begin
				old_x = cal_x;
				cal_x = cal_y;
				cal_y = (mirror_height > old_x) ? mirror_height - old_x : '0;
			end
			p.point_valid = 1'b1;
			p.point_x = cal_x;
			p.point_y = cal_y;
			expected_points.push_back(p);
			valid_seen++;
			clear_touch();
		endfunction

		// Compares one accepted point with the oldest prediction.
		function void check_point(input point_t got);
			point_t want;
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected point: expected none, actual valid %0d x %0d y %0d",
					$time, got.point_valid, got.point_x, got.point_y);
				mismatch_count++;
				return;
			end
			want = expected_points.pop_front();
			if (got.point_valid !== want.point_valid) begin
				$display("%0t: point_valid mismatch: expected %0d, actual %0d",
					$time, want.point_valid, got.point_valid);
				mismatch_count++;
			end
			if (got.point_x !== want.point_x) begin
				$display("%0t: point_x mismatch: expected %0d, actual %0d",
					$time, want.point_x, got.point_x);
				mismatch_count++;
			end
			if (got.point_y !== want.point_y) begin
				$display("%0t: point_y mismatch: expected %0d, actual %0d",
					$time, want.point_y, got.point_y);
				mismatch_count++;
			end
		endfunction

		function int pending_count();
			return expected_points.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	sample_t                smp = '0;
	logic                   smp_valid = 1'b0;
	logic                   smp_stall;
	point_t                 pt;
	logic                   pt_valid;
	logic                   pt_stall = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic [CFG_DATA_W-1:0]  reg_plan [PHASES];
	int                     send_idle_pct = 0;
	int                     stall_pct = 0;
	point_scoreboard        sb = new();

	touch_sample_trimmed_mean_calibrate u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp       (smp),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.pt        (pt),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Random stall on the point channel.
	always @(posedge clk) begin
		pt_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Both handshakes are sampled with their pre-edge values; points are checked first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pt_valid && !pt_stall)
				sb.check_point(pt);
			if (smp_valid && !smp_stall)
				sb.note_sample(smp);
		end
	end

	// Ends the run if no transaction moves for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (smp_valid && !smp_stall) || (pt_valid && !pt_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles, %0d points outstanding",
			$time, QUIET_LIMIT, sb.pending_count());
		$display("status: fail");
		$finish;
	end

	task automatic send_sample(input sample_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			smp_valid <= 1'b0;
			@(posedge clk);
		end
		smp <= s;
		smp_valid <= 1'b1;
		@(posedge clk);
		while (smp_stall)
			@(posedge clk);
	endtask

	task automatic send_xy(input logic pen, input int x, input int y);
		sample_t s;
		s.pen_down = pen;
		s.x_raw = RAW_W'(x);
		s.y_raw = RAW_W'(y);
		send_sample(s);
	endtask

	// Holds the sender off until every predicted point has arrived, then lets
	// the back part settle after samples that produce no point.
	task automatic wait_for_points();
		smp_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Puts random junk above the register's width; only the low bits count.
	function automatic void plan(input int idx, input int unsigned value, input int width);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		if (width < CFG_DATA_W)
			reg_plan[idx] = (junk << width) | CFG_DATA_W'(value);
		else
			reg_plan[idx] = CFG_DATA_W'(value);
	endfunction

	task automatic load_regs();
		for (int i = REG_LOW_LIMIT; i <= REG_MIRROR_HEIGHT; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_INDEX_W'(i);
			cfg_data <= reg_plan[i];
			@(posedge clk);
			sb.set_reg(CFG_INDEX_W'(i), reg_plan[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Chooses the register setting and idling pattern of one phase.
	task automatic setup_phase(input int p);
		int lo;
		case (p)
			1: begin
				// Full-range window so the top raw bits reach the sums.
				plan(REG_LOW_LIMIT, 0, RAW_W);
				plan(REG_HIGH_LIMIT, 8191, RAW_W);
				plan(REG_X_OFFSET, 1023, PIX_W);
				plan(REG_X_GAIN, $urandom_range(0, 8000), GAIN_W);
				plan(REG_Y_OFFSET, 1023, PIX_W);
				plan(REG_Y_GAIN, $urandom_range(0, 8000), GAIN_W);
				plan(REG_SWAP_AXES, 0, 1);
				plan(REG_MIRROR_HEIGHT, $urandom_range(0, 1023), PIX_W);
			end
			2: begin
				plan(REG_LOW_LIMIT, $urandom_range(0, 500), RAW_W);
				plan(REG_HIGH_LIMIT, $urandom_range(3500, 8191), RAW_W);
				plan(REG_X_OFFSET, $urandom_range(0, 1023), PIX_W);
				plan(REG_X_GAIN, $urandom_range(0, 12000), GAIN_W);
				plan(REG_Y_OFFSET, $urandom_range(0, 1023), PIX_W);
				plan(REG_Y_GAIN, $urandom_range(0, 12000), GAIN_W);
				plan(REG_SWAP_AXES, 1, 1);
				plan(REG_MIRROR_HEIGHT, 1023, PIX_W);
			end
			3: begin
				// Empty window: only pen-up samples produce anything.
				plan(REG_LOW_LIMIT, 8191, RAW_W);
				plan(REG_HIGH_LIMIT, 0, RAW_W);
				plan(REG_X_OFFSET, 0, PIX_W);
				plan(REG_X_GAIN, 65535, GAIN_W);
				plan(REG_Y_OFFSET, 0, PIX_W);
				plan(REG_Y_GAIN, 65535, GAIN_W);
				plan(REG_SWAP_AXES, 1, 1);
				plan(REG_MIRROR_HEIGHT, 0, PIX_W);
			end
			4: begin
				// Zero gain gives the offsets; a zero mirror clamps the new Y.
				plan(REG_LOW_LIMIT, 100, RAW_W);
				plan(REG_HIGH_LIMIT, 4000, RAW_W);
				plan(REG_X_OFFSET, $urandom_range(0, 1023), PIX_W);
				plan(REG_X_GAIN, 0, GAIN_W);
				plan(REG_Y_OFFSET, $urandom_range(0, 1023), PIX_W);
				plan(REG_Y_GAIN, 0, GAIN_W);
				plan(REG_SWAP_AXES, 1, 1);
				plan(REG_MIRROR_HEIGHT, 0, PIX_W);
			end
			5: begin
				// Largest gain with zero offset clamps every coordinate.
				plan(REG_LOW_LIMIT, 0, RAW_W);
				plan(REG_HIGH_LIMIT, 8191, RAW_W);
				plan(REG_X_OFFSET, 0, PIX_W);
				plan(REG_X_GAIN, 65535, GAIN_W);
				plan(REG_Y_OFFSET, 0, PIX_W);
				plan(REG_Y_GAIN, 65535, GAIN_W);
				plan(REG_SWAP_AXES, 0, 1);
				plan(REG_MIRROR_HEIGHT, 1023, PIX_W);
			end
			6: begin
				lo = $urandom_range(0, 3000);
				plan(REG_LOW_LIMIT, lo, RAW_W);
				plan(REG_HIGH_LIMIT, $urandom_range(lo, 8191), RAW_W);
				plan(REG_X_OFFSET, $urandom_range(0, 1023), PIX_W);
				plan(REG_X_GAIN, $urandom_range(0, 65535), GAIN_W);
				plan(REG_Y_OFFSET, $urandom_range(0, 1023), PIX_W);
				plan(REG_Y_GAIN, $urandom_range(0, 65535), GAIN_W);
				plan(REG_SWAP_AXES, $urandom_range(0, 1), 1);
				plan(REG_MIRROR_HEIGHT, $urandom_range(0, 1023), PIX_W);
			end
			default: begin
				// Low mirror height so the mirrored Y falls on both sides of the clamp at zero.
				plan(REG_LOW_LIMIT, 100, RAW_W);
				plan(REG_HIGH_LIMIT, 4000, RAW_W);
				plan(REG_X_OFFSET, $urandom_range(0, 1023), PIX_W);
				plan(REG_X_GAIN, 4375, GAIN_W);
				plan(REG_Y_OFFSET, $urandom_range(0, 1023), PIX_W);
				plan(REG_Y_GAIN, 5916, GAIN_W);
				plan(REG_SWAP_AXES, 1, 1);
				plan(REG_MIRROR_HEIGHT, $urandom_range(0, 300), PIX_W);
			end
		endcase
		load_regs();
		case (p % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 59; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 59; end
			default: begin send_idle_pct = 33; stall_pct = 33; end
		endcase
	endtask

	function automatic logic [RAW_W-1:0] window_value(input int lo, input int hi);
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return RAW_W'(lo);
		if (pick == 1)
			return RAW_W'(hi);
		return RAW_W'($urandom_range(lo, hi));
	endfunction

	// Mostly touches made of in-window samples, with some noise and early pen-ups.
	task automatic run_random(input int count);
		sample_t s;
		int      lo, hi, pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			lo = int'(sb.low_limit) + 1;
			hi = int'(sb.high_limit) - 1;
			s.pen_down = 1'b1;
			if (pick < 4) begin
				s.pen_down = 1'b0;
				s.x_raw = RAW_W'($urandom);
				s.y_raw = RAW_W'($urandom);
			end else if (pick < 14 || lo > hi) begin
				s.x_raw = RAW_W'($urandom);
				s.y_raw = RAW_W'($urandom);
			end else begin
				s.x_raw = window_value(lo, hi);
				s.y_raw = window_value(lo, hi);
			end
			send_sample(s);
		end
	endtask

	// Main sequence.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pen-up with nothing kept, carrying all-ones raw values.
		send_xy(1'b0, 8191, 8191);
		// Samples on the window edges are dropped.
		send_xy(1'b1, 100, 500);
		send_xy(1'b1, 4000, 500);
		send_xy(1'b1, 500, 100);
		send_xy(1'b1, 500, 4000);
		send_xy(1'b1, 0, 8191);
		// One full touch whose extremes sit just inside the window.
		for (int i = 0; i < SAMPLE_COUNT; i++) begin
			if (i == 0)
				send_xy(1'b1, 101, 3999);
			else if (i == 1)
				send_xy(1'b1, 3999, 101);
			else
				send_xy(1'b1, 1500 + 100 * i, 2500 - 90 * i);
		end
		// Pen lifted part way through a touch.
		repeat (3) send_xy(1'b1, 3000, 3000);
		send_xy(1'b0, 0, 0);

		run_random(200);
		for (int p = 1; p < PHASES; p++) begin
			wait_for_points();
			setup_phase(p);
			run_random(p == 3 ? 80 : 230);
		end
		wait_for_points();

		$display("Run covered %0d samples (%0d kept) over %0d register settings.",
			sb.samples_seen, sb.kept_seen, PHASES);
		$display("Checked %0d calibrated points and %0d pen-up results, %0d mismatches.",
			sb.valid_seen, sb.pen_up_seen, sb.mismatch_count);
		if (sb.mismatch_count == 0 && sb.pending_count() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/tstmc_pkg.sv
hw/rtl/tstmc_front.sv
hw/rtl/tstmc_fifo.sv
hw/rtl/tstmc_back.sv
hw/rtl/touch_sample_trimmed_mean_calibrate.sv
tb/sv/tb_top.sv
